// ----- hdl/arcp_pkg.sv -----
// Shared types, codes and character constants for the ASCII register command parser.
package arcp_pkg;

    // Result kinds
    localparam logic [1:0] KIND_READ   = 2'd0;
    localparam logic [1:0] KIND_WORD   = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;
    localparam logic [1:0] KIND_WDONE  = 2'd3;

    // Command kinds held while a frame is parsed
    localparam logic [1:0] CMD_UNKNOWN = 2'd0;
    localparam logic [1:0] CMD_READ    = 2'd1;
    localparam logic [1:0] CMD_WRITE   = 2'd2;

    // Fixed field widths
    localparam int ADDR_W  = 17;
    localparam int COUNT_W = 14;
    localparam int WORD_W  = 16;

    // Result queue depth and pointer widths
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // Frame characters
    localparam logic [7:0] CH_R   = 8'h52;
    localparam logic [7:0] CH_W   = 8'h57;
    localparam logic [7:0] CH_D   = 8'h44;
    localparam logic [7:0] CH_S   = 8'h53;
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_H   = 8'h48;
    localparam logic [7:0] CH_0   = 8'h30;
    localparam logic [7:0] CH_9   = 8'h39;
    localparam logic [7:0] CH_UA  = 8'h41;
    localparam logic [7:0] CH_UF  = 8'h46;
    localparam logic [7:0] CH_LA  = 8'h61;
    localparam logic [7:0] CH_LF  = 8'h66;

    typedef struct packed {
        logic [1:0]         kind;
        logic [ADDR_W-1:0]  reg_address;
        logic [COUNT_W-1:0] word_count;
        logic [COUNT_W-1:0] word_index;
        logic [WORD_W-1:0]  word_value;
        logic               short_frame;
        logic               frame_done;
    } result_t;

    // Up to two results per parsed byte: a write word, then a frame close
    typedef struct packed {
        logic    word_valid;
        result_t word;
        logic    close_valid;
        result_t close;
    } step_out_t;

    // Hex digit decode: {bad, value}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'b10000;
        if (c >= CH_0 && c <= CH_9) begin
            r = {1'b0, c[3:0]};
        end else if ((c >= CH_UA && c <= CH_UF) || (c >= CH_LA && c <= CH_LF)) begin
            r = {1'b0, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

// ----- hdl/arcp_parse.sv -----
// Frame parser: per-byte state update and result generation.
module arcp_parse #(
    parameter int ADDR_DIGITS  = 5,
    parameter int COUNT_DIGITS = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic [7:0]          frame_byte,
    input  logic                end_of_frame,
    output arcp_pkg::step_out_t step_out
);

    localparam int ADDR_START_I  = 6;
    localparam int DOT_POS_I     = ADDR_START_I + ADDR_DIGITS;
    localparam int H_POS_I       = DOT_POS_I + 1;
    localparam int COUNT_START_I = H_POS_I + 2;
    localparam int WORD_START_I  = COUNT_START_I + COUNT_DIGITS;
    localparam int POS_W         = $clog2(WORD_START_I + 1);

    localparam logic [POS_W-1:0] P_ADDR  = POS_W'(ADDR_START_I);
    localparam logic [POS_W-1:0] P_DOT   = POS_W'(DOT_POS_I);
    localparam logic [POS_W-1:0] P_H     = POS_W'(H_POS_I);
    localparam logic [POS_W-1:0] P_COUNT = POS_W'(COUNT_START_I);
    localparam logic [POS_W-1:0] P_WORD  = POS_W'(WORD_START_I);

    localparam int AW = arcp_pkg::ADDR_W;
    localparam int CW = arcp_pkg::COUNT_W;
    localparam int WW = arcp_pkg::WORD_W;

    logic [POS_W-1:0] pos_reg,      pos_next;
    logic [1:0]       cmd_reg,      cmd_next;
    logic             rej_reg,      rej_next;
    logic [AW-1:0]    addr_reg,     addr_next;
    logic             addr_bad_reg, addr_bad_next;
    logic [CW-1:0]    cnt_reg,      cnt_next;
    logic             cnt_bad_reg,  cnt_bad_next;
    logic [WW-1:0]    word_reg,     word_next;
    logic             word_bad_reg, word_bad_next;
    logic [2:0]       wci_reg,      wci_next;
    logic [CW-1:0]    seen_reg,     seen_next;

    logic             is_digit;
    logic [3:0]       digit;
    logic [4:0]       hex;
    logic [CW-1:0]    cnt_eff;
    logic [CW-1:0]    cnt_close;
    logic [AW-1:0]    addr_close;
    arcp_pkg::step_out_t out_c;

    assign is_digit = (frame_byte >= arcp_pkg::CH_0) && (frame_byte <= arcp_pkg::CH_9);
    assign digit    = frame_byte[3:0];
    assign hex      = arcp_pkg::hex_decode(frame_byte);
    assign cnt_eff  = cnt_bad_reg ? '0 : cnt_reg;

    // Next state and results for the byte at the parser input
    always_comb begin
        pos_next      = pos_reg;
        cmd_next      = cmd_reg;
        rej_next      = rej_reg;
        addr_next     = addr_reg;
        addr_bad_next = addr_bad_reg;
        cnt_next      = cnt_reg;
        cnt_bad_next  = cnt_bad_reg;
        word_next     = word_reg;
        word_bad_next = word_bad_reg;
        wci_next      = wci_reg;
        seen_next     = seen_reg;
        out_c         = '0;
        cnt_close     = '0;
        addr_close    = '0;

        if (pos_reg < P_WORD) begin
            // Header: command, address, ".H", count
            if (pos_reg == '0) begin
                if (frame_byte == arcp_pkg::CH_R) begin
                    cmd_next = arcp_pkg::CMD_READ;
                end else if (frame_byte == arcp_pkg::CH_W) begin
                    cmd_next = arcp_pkg::CMD_WRITE;
                end else begin
                    cmd_next = arcp_pkg::CMD_UNKNOWN;
                    rej_next = 1'b1;
                end
            end else if (pos_reg == POS_W'(1)) begin
                if (frame_byte != ((cmd_reg == arcp_pkg::CMD_WRITE) ?
                                   arcp_pkg::CH_R : arcp_pkg::CH_D)) begin
                    rej_next = 1'b1;
                end
            end else if (pos_reg == POS_W'(2)) begin
                if (frame_byte != arcp_pkg::CH_S) rej_next = 1'b1;
            end else if (pos_reg >= P_ADDR && pos_reg < P_DOT) begin
                if (is_digit) begin
                    addr_next = {addr_reg[AW-4:0], 3'b000} + {addr_reg[AW-2:0], 1'b0}
                                + AW'(digit);
                end else begin
                    addr_bad_next = 1'b1;
                end
            end else if (pos_reg == P_DOT) begin
                if (frame_byte != arcp_pkg::CH_DOT) rej_next = 1'b1;
            end else if (pos_reg == P_H) begin
                if (frame_byte != arcp_pkg::CH_H) rej_next = 1'b1;
            end else if (pos_reg >= P_COUNT) begin
                if (is_digit) begin
                    cnt_next = {cnt_reg[CW-4:0], 3'b000} + {cnt_reg[CW-2:0], 1'b0}
                               + CW'(digit);
                end else begin
                    cnt_bad_next = 1'b1;
                end
            end
            pos_next = pos_reg + POS_W'(1);
        end else if (cmd_reg == arcp_pkg::CMD_WRITE && !rej_reg) begin
            // Write words: separator then four hex digits
            if (wci_reg == 3'd0) begin
                wci_next      = 3'd1;
                word_next     = '0;
                word_bad_next = 1'b0;
            end else begin
                if (hex[4]) begin
                    word_bad_next = 1'b1;
                end else begin
                    word_next = {word_reg[WW-5:0], hex[3:0]};
                end
                if (wci_reg >= 3'd4) begin
                    if (seen_reg < cnt_eff) begin
                        out_c.word_valid       = 1'b1;
                        out_c.word.kind        = arcp_pkg::KIND_WORD;
                        out_c.word.reg_address = addr_bad_reg ? '0 : addr_reg;
                        out_c.word.word_count  = cnt_eff;
                        out_c.word.word_index  = seen_reg;
                        out_c.word.word_value  = word_bad_next ? '0 : word_next;
                        seen_next              = seen_reg + CW'(1);
                    end
                    wci_next = 3'd0;
                end else begin
                    wci_next = wci_reg + 3'd1;
                end
            end
        end

        // Frame close on the flagged last byte
        if (end_of_frame) begin
            addr_close              = addr_bad_next ? '0 : addr_next;
            cnt_close               = cnt_bad_next ? '0 : cnt_next;
            out_c.close_valid       = 1'b1;
            out_c.close.frame_done  = 1'b1;
            if (rej_next || cmd_next == arcp_pkg::CMD_UNKNOWN || pos_next <= P_H) begin
                out_c.close.kind = arcp_pkg::KIND_REJECT;
            end else if (cmd_next == arcp_pkg::CMD_READ) begin
                out_c.close.kind        = arcp_pkg::KIND_READ;
                out_c.close.reg_address = addr_close;
                out_c.close.word_count  = cnt_close;
            end else begin
                out_c.close.kind        = arcp_pkg::KIND_WDONE;
                out_c.close.reg_address = addr_close;
                out_c.close.word_count  = cnt_close;
                out_c.close.short_frame = (seen_next < cnt_close);
            end
            pos_next      = '0;
            cmd_next      = arcp_pkg::CMD_UNKNOWN;
            rej_next      = 1'b0;
            addr_next     = '0;
            addr_bad_next = 1'b0;
            cnt_next      = '0;
            cnt_bad_next  = 1'b0;
            word_next     = '0;
            word_bad_next = 1'b0;
            wci_next      = 3'd0;
            seen_next     = '0;
        end
    end

    assign step_out = step ? out_c : '0;

    // Parser state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            cmd_reg      <= arcp_pkg::CMD_UNKNOWN;
            rej_reg      <= 1'b0;
            addr_reg     <= '0;
            addr_bad_reg <= 1'b0;
            cnt_reg      <= '0;
            cnt_bad_reg  <= 1'b0;
            word_reg     <= '0;
            word_bad_reg <= 1'b0;
            wci_reg      <= 3'd0;
            seen_reg     <= '0;
        end else if (step) begin
            pos_reg      <= pos_next;
            cmd_reg      <= cmd_next;
            rej_reg      <= rej_next;
            addr_reg     <= addr_next;
            addr_bad_reg <= addr_bad_next;
            cnt_reg      <= cnt_next;
            cnt_bad_reg  <= cnt_bad_next;
            word_reg     <= word_next;
            word_bad_reg <= word_bad_next;
            wci_reg      <= wci_next;
            seen_reg     <= seen_next;
        end
    end

endmodule

// ----- hdl/arcp_rfifo.sv -----
// Result queue: takes up to two results per cycle, hands out one.
module arcp_rfifo (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  arcp_pkg::step_out_t               push,
    input  logic                              pop,
    output logic                              out_valid,
    output arcp_pkg::result_t                 out_data,
    output logic                              room2,
    output logic [arcp_pkg::QCNT_W-1:0]       level
);

    arcp_pkg::result_t               mem [arcp_pkg::QDEPTH];
    logic [arcp_pkg::QPTR_W-1:0]     wr_reg, wr_next;
    logic [arcp_pkg::QPTR_W-1:0]     rd_reg, rd_next;
    logic [arcp_pkg::QCNT_W-1:0]     cnt_reg, cnt_next;
    logic [arcp_pkg::QPTR_W-1:0]     wr_second;
    logic [1:0]                      n_push;
    logic                            do_pop;

    assign out_valid = (cnt_reg != '0);
    assign out_data  = mem[rd_reg];
    assign room2     = (cnt_reg <= arcp_pkg::QCNT_W'(arcp_pkg::QDEPTH - 2));
    assign level     = cnt_reg;
    assign do_pop    = pop && out_valid;

    // Pointer and level bookkeeping
    always_comb begin
        n_push    = {1'b0, push.word_valid} + {1'b0, push.close_valid};
        wr_second = wr_reg + arcp_pkg::QPTR_W'(push.word_valid);
        wr_next   = wr_reg + arcp_pkg::QPTR_W'(n_push);
        rd_next   = rd_reg + arcp_pkg::QPTR_W'(do_pop);
        cnt_next  = cnt_reg + arcp_pkg::QCNT_W'(n_push) - arcp_pkg::QCNT_W'(do_pop);
    end

    // Entry writes, word result ahead of the close
    always_ff @(posedge aclk) begin
        if (push.word_valid) mem[wr_reg] <= push.word;
        if (push.close_valid) mem[wr_second] <= push.close;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- hdl/ascii_register_command_parser_top.sv -----
// An accepted byte is parsed from the input register; its results reach m_ via the queue.
// Throughput: one byte per cycle; a byte that yields both a write word and the frame close
//   puts two results out, one per cycle, through a four-entry result queue.
// The parser steps only while the queue has room for two results.
// Reset (aresetn low, synchronous) clears the input register, parser state and queue;
//   no clearing pass is needed.
module ascii_register_command_parser_top #(
    parameter int ADDR_DIGITS  = 5,
    parameter int COUNT_DIGITS = 4
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_frame_byte,
    input  logic                              s_end_of_frame,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_kind,
    output logic [arcp_pkg::ADDR_W-1:0]       m_reg_address,
    output logic [arcp_pkg::COUNT_W-1:0]      m_word_count,
    output logic [arcp_pkg::COUNT_W-1:0]      m_word_index,
    output logic [arcp_pkg::WORD_W-1:0]       m_word_value,
    output logic                              m_short_frame,
    output logic                              m_frame_done
);

    logic                        in_valid_reg;
    logic [7:0]                  byte_reg;
    logic                        eof_reg;
    logic                        step;
    logic                        room2;
    logic [arcp_pkg::QCNT_W-1:0] level;
    arcp_pkg::step_out_t         step_out;
    arcp_pkg::result_t           res;

    // Parse the held request when the queue can take both possible results
    assign step    = in_valid_reg && room2;
    assign s_ready = !in_valid_reg || step;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_frame_byte;
            eof_reg  <= s_end_of_frame;
        end
    end

    arcp_parse #(
        .ADDR_DIGITS  (ADDR_DIGITS),
        .COUNT_DIGITS (COUNT_DIGITS)
    ) u_parse (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (step),
        .frame_byte   (byte_reg),
        .end_of_frame (eof_reg),
        .step_out     (step_out)
    );

    arcp_rfifo u_rfifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (step_out),
        .pop       (m_ready),
        .out_valid (m_valid),
        .out_data  (res),
        .room2     (room2),
        .level     (level)
    );

    assign m_kind        = res.kind;
    assign m_reg_address = res.reg_address;
    assign m_word_count  = res.word_count;
    assign m_word_index  = res.word_index;
    assign m_word_value  = res.word_value;
    assign m_short_frame = res.short_frame;
    assign m_frame_done  = res.frame_done;

    // Queue never overfills
    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        level <= arcp_pkg::QCNT_W'(arcp_pkg::QDEPTH))
        else $error("result queue overflow");

    // An accepted request is held for the parser
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> in_valid_reg)
        else $error("accepted request lost");

    // Write words never close a frame; every close carries frame_done
    a_done_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_frame_done == (m_kind != arcp_pkg::KIND_WORD)))
        else $error("frame_done inconsistent with kind");

    // A parsed byte flagged last always yields a close result
    a_close: assert property (@(posedge aclk) disable iff (!aresetn)
        step && eof_reg |-> step_out.close_valid)
        else $error("missing frame close");

endmodule

// ----- dv/ascii_register_command_parser_top_tb.sv -----
// Testbench for the ASCII register command parser: random RDS/WRS frames against a predictor.
`timescale 1ns / 1ps

module ascii_register_command_parser_top_tb;

    // Frame layout for the default digit counts
    localparam int ADDR_DIGITS  = 5;
    localparam int COUNT_DIGITS = 4;
    localparam int ADDR_START   = 6;
    localparam int DOT_POS      = ADDR_START + ADDR_DIGITS;
    localparam int H_POS        = DOT_POS + 1;
    localparam int COUNT_START  = H_POS + 2;
    localparam int WORD_START   = COUNT_START + COUNT_DIGITS;
    localparam int BYTE_TARGET  = 1150;

    // Parser model plus the queue of results still owed by the block
    class frame_scoreboard;
        logic [4:0]                   char_pos;
        logic [1:0]                   cmd;
        bit                           rejected;
        logic [arcp_pkg::ADDR_W-1:0]  addr_acc;
        bit                           addr_bad;
        logic [arcp_pkg::COUNT_W-1:0] count_acc;
        bit                           count_bad;
        logic [arcp_pkg::WORD_W-1:0]  word_acc;
        bit                           word_bad;
        logic [2:0]                   word_digit;
        logic [arcp_pkg::COUNT_W-1:0] words_done;
        arcp_pkg::result_t            expected_results[$];
        int                           errors;

        function new();
            errors = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            char_pos   = '0;
            cmd        = arcp_pkg::CMD_UNKNOWN;
            rejected   = 1'b0;
            addr_acc   = '0;
            addr_bad   = 1'b0;
            count_acc  = '0;
            count_bad  = 1'b0;
            word_acc   = '0;
            word_bad   = 1'b0;
            word_digit = '0;
            words_done = '0;
        endfunction

        function int hex_digit(logic [7:0] c);
            if (c >= "0" && c <= "9") return int'(c) - "0";
            if (c >= "A" && c <= "F") return int'(c) - "A" + 10;
            if (c >= "a" && c <= "f") return int'(c) - "a" + 10;
            return -1;
        endfunction

        function void push_result(logic [1:0] kind, logic [arcp_pkg::ADDR_W-1:0] addr,
                                  logic [arcp_pkg::COUNT_W-1:0] cnt,
                                  logic [arcp_pkg::COUNT_W-1:0] idx,
                                  logic [arcp_pkg::WORD_W-1:0] val, logic shrt, logic done);
            arcp_pkg::result_t r;
            r.kind        = kind;
            r.reg_address = addr;
            r.word_count  = cnt;
            r.word_index  = idx;
            r.word_value  = val;
            r.short_frame = shrt;
            r.frame_done  = done;
            expected_results.push_back(r);
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // Called once per accepted request
        function void note_byte(logic [7:0] c, logic eof);
            int                           h;
            int                           acc;
            logic [arcp_pkg::COUNT_W-1:0] cnt;
            logic [arcp_pkg::ADDR_W-1:0]  addr;
            if (char_pos < WORD_START) begin
                // header: command, address, ".H", count
                if (char_pos == 0) begin
                    if (c == arcp_pkg::CH_R) cmd = arcp_pkg::CMD_READ;
                    else if (c == arcp_pkg::CH_W) cmd = arcp_pkg::CMD_WRITE;
                    else begin
                        cmd = arcp_pkg::CMD_UNKNOWN;
                        rejected = 1'b1;
                    end
                end else if (char_pos == 1) begin
                    if (c != ((cmd == arcp_pkg::CMD_WRITE) ? arcp_pkg::CH_R : arcp_pkg::CH_D))
                        rejected = 1'b1;
                end else if (char_pos == 2) begin
                    if (c != arcp_pkg::CH_S) rejected = 1'b1;
                end else if (char_pos >= ADDR_START && char_pos < DOT_POS) begin
                    if (c >= arcp_pkg::CH_0 && c <= arcp_pkg::CH_9) begin
                        acc = int'(addr_acc) * 10 + int'(c - arcp_pkg::CH_0);
                        addr_acc = acc[arcp_pkg::ADDR_W-1:0];
                    end else begin
                        addr_bad = 1'b1;
                    end
                end else if (char_pos == DOT_POS) begin
                    if (c != arcp_pkg::CH_DOT) rejected = 1'b1;
                end else if (char_pos == H_POS) begin
                    if (c != arcp_pkg::CH_H) rejected = 1'b1;
                end else if (char_pos >= COUNT_START) begin
                    if (c >= arcp_pkg::CH_0 && c <= arcp_pkg::CH_9) begin
                        acc = int'(count_acc) * 10 + int'(c - arcp_pkg::CH_0);
                        count_acc = acc[arcp_pkg::COUNT_W-1:0];
                    end else begin
                        count_bad = 1'b1;
                    end
                end
                char_pos = char_pos + 1'b1;
            end else if (cmd == arcp_pkg::CMD_WRITE && !rejected) begin
                // write words: separator, then four hex digits
                if (word_digit == 0) begin
                    word_digit = 3'd1;
                    word_acc   = '0;
                    word_bad   = 1'b0;
                end else begin
                    h = hex_digit(c);
                    if (h < 0) word_bad = 1'b1;
                    else word_acc = {word_acc[arcp_pkg::WORD_W-5:0], h[3:0]};
                    if (word_digit >= 4) begin
                        cnt = count_bad ? '0 : count_acc;
                        if (words_done < cnt) begin
                            push_result(arcp_pkg::KIND_WORD, addr_bad ? '0 : addr_acc, cnt,
                                        words_done, word_bad ? '0 : word_acc, 1'b0, 1'b0);
                            words_done = words_done + 1'b1;
                        end
                        word_digit = '0;
                    end else begin
                        word_digit = word_digit + 1'b1;
                    end
                end
            end

            // frame close
            if (eof) begin
                addr = addr_bad ? '0 : addr_acc;
                cnt  = count_bad ? '0 : count_acc;
                if (rejected || cmd == arcp_pkg::CMD_UNKNOWN || char_pos <= H_POS)
                    push_result(arcp_pkg::KIND_REJECT, '0, '0, '0, '0, 1'b0, 1'b1);
                else if (cmd == arcp_pkg::CMD_READ)
                    push_result(arcp_pkg::KIND_READ, addr, cnt, '0, '0, 1'b0, 1'b1);
                else
                    push_result(arcp_pkg::KIND_WDONE, addr, cnt, '0, '0,
                                words_done < cnt, 1'b1);
                clear_frame();
            end
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(arcp_pkg::result_t got);
            arcp_pkg::result_t want;
            if (expected_results.size() == 0) begin
                $error("result with nothing expected: kind %0d", got.kind);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("kind", 32'(want.kind), 32'(got.kind));
            compare_field("reg_address", 32'(want.reg_address), 32'(got.reg_address));
            compare_field("word_count", 32'(want.word_count), 32'(got.word_count));
            compare_field("word_index", 32'(want.word_index), 32'(got.word_index));
            compare_field("word_value", 32'(want.word_value), 32'(got.word_value));
            compare_field("short_frame", 32'(want.short_frame), 32'(got.short_frame));
            compare_field("frame_done", 32'(want.frame_done), 32'(got.frame_done));
        endfunction
    endclass

    logic                           aclk;
    logic                           aresetn;
    logic                           s_valid;
    logic                           s_ready;
    logic [7:0]                     s_frame_byte;
    logic                           s_end_of_frame;
    logic                           m_valid;
    logic                           m_ready;
    logic [1:0]                     m_kind;
    logic [arcp_pkg::ADDR_W-1:0]    m_reg_address;
    logic [arcp_pkg::COUNT_W-1:0]   m_word_count;
    logic [arcp_pkg::COUNT_W-1:0]   m_word_index;
    logic [arcp_pkg::WORD_W-1:0]    m_word_value;
    logic                           m_short_frame;
    logic                           m_frame_done;

    frame_scoreboard      sb = new();
    logic [7:0]           frame_q[$];
    int                   bytes_sent;
    bit                   steady;

    ascii_register_command_parser_top DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_frame_byte   (s_frame_byte),
        .s_end_of_frame (s_end_of_frame),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_reg_address  (m_reg_address),
        .m_word_count   (m_word_count),
        .m_word_index   (m_word_index),
        .m_word_value   (m_word_value),
        .m_short_frame  (m_short_frame),
        .m_frame_done   (m_frame_done)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    // Result side back-pressure, off during the steady stretch
    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= 6);
    end

    // Result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result('{m_kind, m_reg_address, m_word_count, m_word_index,
                              m_word_value, m_short_frame, m_frame_done});
        end
    end

    // Watchdog
    initial begin
        #3_000_000;
        $display("** ascii_register_command_parser_top: FAILED **");
        $finish;
    end

    // Random helpers for frame content
    function automatic logic [7:0] pick_hex(int bad_pct);
        int v;
        v = $urandom_range(0, 15);
        if ($urandom_range(0, 99) < bad_pct) return 8'($urandom_range(0, 255));
        if (v < 10) return arcp_pkg::CH_0 + 8'(v);
        return ($urandom_range(0, 1) ? arcp_pkg::CH_UA : arcp_pkg::CH_LA) + 8'(v - 10);
    endfunction

    function automatic logic [7:0] maybe_corrupt(logic [7:0] c, int bad_pct);
        if ($urandom_range(0, 99) < bad_pct) return 8'($urandom_range(0, 255));
        return c;
    endfunction

    task automatic append_text(string s);
        for (int i = 0; i < s.len(); i++) frame_q.push_back(s[i]);
    endtask

    task automatic append_decimal(int value, int ndigits, int bad_pct);
        int divisor;
        logic [7:0] c;
        divisor = 1;
        for (int i = 1; i < ndigits; i++) divisor = divisor * 10;
        for (int i = 0; i < ndigits; i++) begin
            c = arcp_pkg::CH_0 + 8'((value / divisor) % 10);
            frame_q.push_back(maybe_corrupt(c, bad_pct));
            divisor = divisor / 10;
        end
    endtask

    // One request: random idle first, then hold valid until accepted
    task automatic send_byte(logic [7:0] c, logic eof);
        while (!steady && $urandom_range(0, 99) < 6) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_frame_byte   <= c;
        s_end_of_frame <= eof;
        do @(posedge aclk); while (!s_ready);
        sb.note_byte(c, eof);
        bytes_sent++;
        steady = (bytes_sent >= 500 && bytes_sent < 760);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_q.size(); i++) send_byte(frame_q[i], i == frame_q.size() - 1);
        frame_q.delete();
    endtask

    // Mostly well-formed RDS/WRS frames with random content, some noise and damage
    task automatic build_frame();
        int sel;
        int count;
        int nwords;
        int cut;
        bit is_write;
        sel = $urandom_range(0, 99);
        if (sel < 8) begin
            repeat ($urandom_range(1, 30)) frame_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        is_write = 1'($urandom_range(0, 1));
        frame_q.push_back(maybe_corrupt(is_write ? arcp_pkg::CH_W : arcp_pkg::CH_R, 4));
        frame_q.push_back(maybe_corrupt(is_write ? arcp_pkg::CH_R : arcp_pkg::CH_D, 4));
        frame_q.push_back(maybe_corrupt(arcp_pkg::CH_S, 4));
        repeat (3) frame_q.push_back(8'($urandom_range(0, 255)));
        case ($urandom_range(0, 9))
            0: append_decimal(0, ADDR_DIGITS, 5);
            1: append_decimal(99999, ADDR_DIGITS, 5);
            default: append_decimal($urandom_range(0, 99999), ADDR_DIGITS, 5);
        endcase
        frame_q.push_back(maybe_corrupt(arcp_pkg::CH_DOT, 3));
        frame_q.push_back(maybe_corrupt(arcp_pkg::CH_H, 3));
        frame_q.push_back(8'($urandom_range(0, 255)));
        sel = $urandom_range(0, 99);
        if (sel < 70) count = $urandom_range(0, 6);
        else if (sel < 80) count = 9999;
        else if (sel < 88) count = 0;
        else count = $urandom_range(0, 9999);
        append_decimal(count, COUNT_DIGITS, 4);
        if (is_write) begin
            nwords = $urandom_range(0, ((count < 6) ? count : 6) + 2);
            for (int w = 0; w < nwords; w++) begin
                frame_q.push_back(8'($urandom_range(0, 255)));
                sel = $urandom_range(0, 9);
                if (sel == 0) append_text("FFFF");
                else if (sel == 1) append_text("0000");
                else repeat (4) frame_q.push_back(pick_hex(5));
            end
            // word cut off by the end of the frame
            if ($urandom_range(0, 99) < 15) begin
                frame_q.push_back(8'($urandom_range(0, 255)));
                repeat ($urandom_range(0, 3)) frame_q.push_back(pick_hex(0));
            end
        end else if ($urandom_range(0, 99) < 30) begin
            repeat ($urandom_range(1, 5)) frame_q.push_back(8'($urandom_range(0, 255)));
        end
        // early end: inside the header, the address, the count or the words
        if ($urandom_range(0, 99) < 12) begin
            cut = $urandom_range(1, frame_q.size());
            while (frame_q.size() > cut) void'(frame_q.pop_back());
        end
    endtask

    // Stimulus and end of run
    initial begin
        int frames;
        int drain_cycles;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_frame_byte   = '0;
        s_end_of_frame = 1'b0;
        m_ready        = 1'b0;
        bytes_sent     = 0;
        steady         = 1'b0;
        frames         = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: full-range write of one word, then a one-byte bad frame
        append_text("WRS DM99999.H 0001 FFFF");
        send_frame();
        append_text("X");
        send_frame();

        while (bytes_sent < BYTE_TARGET) begin
            build_frame();
            send_frame();
            frames++;
            // hold the sender until the block has drained
            if (frames == 15) begin
                s_valid <= 1'b0;
                do @(posedge aclk); while (sb.pending() != 0);
            end
        end
        s_valid <= 1'b0;

        drain_cycles = 0;
        while (sb.pending() != 0 && drain_cycles < 20000) begin
            @(posedge aclk);
            drain_cycles++;
        end
        if (sb.pending() != 0) begin
            $error("%0d expected results never arrived", sb.pending());
            sb.errors++;
        end
        repeat (20) @(posedge aclk);

        if (sb.errors == 0) begin
            $display("** ascii_register_command_parser_top: PASSED **");
        end else begin
            $display("** ascii_register_command_parser_top: FAILED **");
        end
        $finish;
    end

endmodule
